// ----- rtl/ert_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_pkg
// Shared types and constants of the echo request tracker: item layouts,
// kind, type and status codes, register indexes and controller commands.
// ----------------------------------------------------------------------------
package ert_pkg;

  // default depth of the pending request table
  localparam int unsigned PENDING_ENTRIES_DEF = 8;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLY_ENABLE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AGE_LIMIT    = 8'd1;
  localparam logic [31:0]            AGE_LIMIT_RESET  = 32'd1000;

  // packet header length and message types
  localparam logic [15:0] HEADER_BYTES      = 16'd8;
  localparam logic [7:0]  TYPE_ECHO_REPLY   = 8'd0;
  localparam logic [7:0]  TYPE_UNREACH      = 8'd3;
  localparam logic [7:0]  TYPE_ECHO_REQUEST = 8'd8;

  // item kinds
  typedef enum logic [1:0] {
    KIND_TICK       = 2'd0,
    KIND_SEND_REQ   = 2'd1,
    KIND_SEND_REPLY = 2'd2,
    KIND_RX_PACKET  = 2'd3
  } kind_t;

  // result status
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_ERROR = 2'd1,
    STATUS_SHORT = 2'd2
  } status_t;

  // input item, first field in the highest bits
  typedef struct packed {
    logic [31:0] source_addr;
    logic [15:0] pkt_length;
    logic [7:0]  msg_type;
    logic [15:0] echo_seq;
    logic [15:0] echo_id;
    logic [15:0] elapsed;
  } in_item_t;

  // result item, first field in the highest bits
  typedef struct packed {
    logic [31:0] errors_seen;
    logic [31:0] unreach_seen;
    logic [31:0] replies_seen;
    logic [31:0] requests_sent;
    logic [31:0] reply_rtt_ms;
    logic [15:0] reply_seq;
    logic [31:0] reply_from;
  } out_item_t;

  localparam int unsigned IN_TDATA_W  = $bits(in_item_t);
  localparam int unsigned OUT_TDATA_W = $bits(out_item_t);
  localparam int unsigned OUT_TUSER_W = 3;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic eval;
    logic commit;
  } dp_cmd_t;

endpackage

// ----- rtl/ert_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_ctrl
// Sequencer of the tracker: takes an item, runs the table lookup, then
// commits the update and the result once the output register is free.
// ----------------------------------------------------------------------------
module ert_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output ert_pkg::dp_cmd_t cmd
);
  import ert_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EVAL   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   commit_ok;

  assign s_tready  = (state == S_IDLE);
  assign m_tvalid  = out_valid;
  assign commit_ok = (state == S_COMMIT) && (!out_valid || m_tready);

  assign cmd.load   = s_tvalid && s_tready;
  assign cmd.eval   = (state == S_EVAL);
  assign cmd.commit = commit_ok;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_tvalid) state_next = S_EVAL;
      S_EVAL:   state_next = S_COMMIT;
      S_COMMIT: if (commit_ok) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit_ok) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/ert_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_datapath
// Pending request table, configuration registers, wrapping counters and
// the result register. Lookup is registered in one step, update in the next.
// ----------------------------------------------------------------------------
module ert_datapath #(
  parameter int unsigned PENDING_ENTRIES = ert_pkg::PENDING_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ert_pkg::dp_cmd_t                    cmd,
  input  ert_pkg::kind_t                      in_kind,
  input  ert_pkg::in_item_t                   in_item,
  input  logic                                cfg_we,
  input  logic [ert_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ert_pkg::CFG_DATA_W-1:0]      cfg_data,
  output ert_pkg::out_item_t                  out_item,
  output ert_pkg::status_t                    out_status,
  output logic                                out_matched
);
  import ert_pkg::*;

  localparam int unsigned N     = PENDING_ENTRIES;
  localparam int unsigned CNT_W = $clog2(N + 1);
  localparam logic [N-1:0] ONE_N = N'(1);

  // configuration
  logic        reply_enable;
  logic [31:0] age_limit;

  // captured item
  kind_t    kind_q;
  in_item_t item_q;

  // table
  logic [N-1:0] entry_valid;
  logic [15:0]  entry_ident [N];
  logic [31:0]  entry_age   [N];

  // lookup
  logic [N-1:0]     match_vec;
  logic [N-1:0]     expire_vec;
  logic [N-1:0]     free_vec;
  logic [N-1:0]     match_low;
  logic [N-1:0]     free_low;
  logic [31:0]      rtt_mux;
  logic [N-1:0]     match_sel_q;
  logic [N-1:0]     free_sel_q;
  logic [N-1:0]     expire_q;
  logic [CNT_W-1:0] expire_cnt_q;
  logic [31:0]      rtt_q;
  logic             hit_q;

  // counters
  logic [31:0] request_counter;
  logic [31:0] reply_counter;
  logic [31:0] unreach_counter;
  logic [31:0] error_counter;
  logic [31:0] request_counter_next;
  logic [31:0] reply_counter_next;
  logic [31:0] unreach_counter_next;
  logic [31:0] error_counter_next;

  // commit decisions
  status_t status_c;
  logic    do_tick;
  logic    do_claim;
  logic    do_release;
  logic    inc_req;
  logic    inc_rep;
  logic    inc_unr;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_enable <= 1'b1;
      age_limit    <= AGE_LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_REPLY_ENABLE) reply_enable <= cfg_data[0];
      if (cfg_index == REG_AGE_LIMIT)    age_limit    <= cfg_data[31:0];
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= in_kind;
      item_q <= in_item;
    end
  end

  // per-entry compares
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_vec[i]  = entry_valid[i] && (entry_ident[i] == item_q.echo_id);
      expire_vec[i] = entry_valid[i] && (entry_age[i] >= age_limit);
    end
    free_vec  = ~entry_valid;
    match_low = match_vec & (~match_vec + ONE_N);
    free_low  = free_vec & (~free_vec + ONE_N);
  end

  // age of the selected entry
  always_comb begin
    rtt_mux = '0;
    for (int i = 0; i < N; i++) begin
      rtt_mux = rtt_mux | (entry_age[i] & {32{match_low[i]}});
    end
  end

  // lookup register
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      match_sel_q  <= match_low;
      free_sel_q   <= free_low;
      expire_q     <= expire_vec;
      expire_cnt_q <= CNT_W'($countones(expire_vec));
      rtt_q        <= rtt_mux;
      hit_q        <= |match_vec;
    end
  end

  // dispatch by kind and message type
  always_comb begin
    status_c   = STATUS_OK;
    do_tick    = 1'b0;
    do_claim   = 1'b0;
    do_release = 1'b0;
    inc_req    = 1'b0;
    inc_rep    = 1'b0;
    inc_unr    = 1'b0;
    unique case (kind_q)
      KIND_TICK: do_tick = 1'b1;
      KIND_SEND_REQ: begin
        do_claim = 1'b1;
        inc_req  = 1'b1;
      end
      KIND_SEND_REPLY: begin
        if (reply_enable) inc_rep = 1'b1;
        else status_c = STATUS_ERROR;
      end
      KIND_RX_PACKET: begin
        if (item_q.pkt_length < HEADER_BYTES) begin
          status_c = STATUS_SHORT;
        end else if (item_q.msg_type == TYPE_ECHO_REQUEST) begin
          if (reply_enable) inc_rep = 1'b1;
          else status_c = STATUS_ERROR;
        end else if (item_q.msg_type == TYPE_ECHO_REPLY) begin
          do_release = hit_q;
          inc_rep    = hit_q;
        end else if (item_q.msg_type == TYPE_UNREACH) begin
          inc_unr = 1'b1;
        end else begin
          status_c = STATUS_ERROR;
        end
      end
      default: status_c = STATUS_ERROR;
    endcase
  end

  // counter next values
  always_comb begin
    request_counter_next = request_counter + {31'd0, inc_req};
    reply_counter_next   = reply_counter + {31'd0, inc_rep};
    unreach_counter_next = unreach_counter + {31'd0, inc_unr};
    error_counter_next   = error_counter;
    if (do_tick) error_counter_next = error_counter + 32'(expire_cnt_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      request_counter <= '0;
      reply_counter   <= '0;
      unreach_counter <= '0;
      error_counter   <= '0;
    end else if (cmd.commit) begin
      request_counter <= request_counter_next;
      reply_counter   <= reply_counter_next;
      unreach_counter <= unreach_counter_next;
      error_counter   <= error_counter_next;
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.commit) begin
      for (int i = 0; i < N; i++) begin
        if (do_tick && expire_q[i]) entry_valid[i] <= 1'b0;
        if (do_claim && free_sel_q[i]) entry_valid[i] <= 1'b1;
        if (do_release && match_sel_q[i]) entry_valid[i] <= 1'b0;
      end
    end
  end

  // entry id and age, aging saturates at all ones
  always_ff @(posedge clk) begin
    logic [32:0] sum;
    if (cmd.commit) begin
      for (int i = 0; i < N; i++) begin
        sum = {1'b0, entry_age[i]} + {17'd0, item_q.elapsed};
        if (do_tick && entry_valid[i] && !expire_q[i]) begin
          entry_age[i] <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        if (do_claim && free_sel_q[i]) begin
          entry_ident[i] <= item_q.echo_id;
          entry_age[i]   <= '0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status                 <= status_c;
      out_matched                <= do_release;
      out_item.reply_from        <= do_release ? item_q.source_addr : 32'd0;
      out_item.reply_seq         <= do_release ? item_q.echo_seq : 16'd0;
      out_item.reply_rtt_ms      <= do_release ? rtt_q : 32'd0;
      out_item.requests_sent     <= request_counter_next;
      out_item.replies_seen      <= reply_counter_next;
      out_item.unreach_seen      <= unreach_counter_next;
      out_item.errors_seen       <= error_counter_next;
    end
  end

endmodule

// ----- rtl/echo_request_tracker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_request_tracker_unit
// Tracks outstanding echo requests, ages them on ticks, matches replies
// and keeps wrapping request, reply, unreachable and error counters.
// ----------------------------------------------------------------------------
// Each accepted item yields exactly one result. An item passes these steps:
// the transfer, an evaluation step in which all table entries are compared in
// parallel and the lowest match and lowest free entry are registered, and
// a commit step that updates the table and counters and loads the result
// register. A new item is taken in the cycle after the commit; the block
// takes no new item before the last one is done. The update waits only
// when the result register still holds a result that has not been taken.
// Configuration writes are always ready and must be issued while idle.
module echo_request_tracker_unit #(
  parameter int unsigned PENDING_ENTRIES = ert_pkg::PENDING_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // tdata: elapsed, echo_id, echo_seq, msg_type, pkt_length, source_addr
  input  logic [ert_pkg::IN_TDATA_W-1:0]   s_tdata,
  // tuser: kind
  input  logic [1:0]                       s_tuser,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // tdata: reply_from, reply_seq, reply_rtt_ms, requests_sent,
  //        replies_seen, unreach_seen, errors_seen
  output logic [ert_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // tuser: status, reply_matched
  output logic [ert_pkg::OUT_TUSER_W-1:0]  m_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ert_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ert_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ert_pkg::*;

  dp_cmd_t   cmd;
  out_item_t out_item;
  status_t   out_status;
  logic      out_matched;

  assign cfg_ready = 1'b1;

  // sequencer
  ert_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // table, counters and result
  ert_datapath #(
    .PENDING_ENTRIES (PENDING_ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_kind     (kind_t'(s_tuser)),
    .in_item     (in_item_t'(s_tdata)),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_item    (out_item),
    .out_status  (out_status),
    .out_matched (out_matched)
  );

  // result packing
  assign m_tdata = out_item;
  assign m_tuser = {out_matched, out_status};

endmodule
